@@ rtl/tssv_pkg.sv @@
// Shared types and constants of the twisted spline strip vertex generator.
`default_nettype none

package tssv_pkg;

    // Angles in 1/256 degree
    localparam int unsigned FULL_TURN    = 92160;
    localparam int unsigned HALF_TURN    = 46080;
    localparam int unsigned QUARTER_TURN = 23040;

    // Reciprocal of a full turn, scaled by 2^TURN_SHIFT and rounded up
    localparam logic [27:0] TURN_RECIP = 28'd190887436;
    localparam int          TURN_SHIFT = 44;

    // Multiple of a full turn that makes any twist value nonnegative
    localparam logic [24:0] TWIST_BIAS = 25'd8478720;

    // CORDIC start vector, Q2.30
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Quotient bits kept by the curve divider
    localparam int QBITS = 20;

    typedef logic signed [15:0] coord_t;

    typedef enum logic [2:0] {
        REG_POINT_ONE   = 3'd0,
        REG_POINT_TWO   = 3'd1,
        REG_POINT_THREE = 3'd2,
        REG_POINT_FOUR  = 3'd3,
        REG_TWIST       = 3'd4,
        REG_LEVEL_COUNT = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        CORNER_LL = 2'd0,
        CORNER_UL = 2'd1,
        CORNER_LR = 2'd2,
        CORNER_UR = 2'd3
    } corner_t;

    // atan(2^-k) in 1/65536 degree
    function automatic logic [21:0] atan_entry(input logic [4:0] k);
        logic [21:0] a;
        case (k)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            5'd20:   a = 22'd4;
            5'd21:   a = 22'd2;
            5'd22:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/twisted_spline_strip_vertices_core.sv @@
// Top level: pipelined Catmull-Rom sampler, divider, CORDIC twist and quad serializer.
// Vertices of a level appear after stages E0 to E6, the divider, CORDIC, M1 and M2;
// the four vertices follow on consecutive cycles. After each transfer, busy holds off
// the next level, a pace set by the single result port that carries four vertices per
// level; the pipeline holds many levels at once. Reset clears the registers to zero
// points, zero twist and one level, and empties the pipeline. The receiver cannot stall.
`default_nettype none

module twisted_spline_strip_vertices_core #(
    parameter int MAX_LEVELS   = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [9:0]          level,
    input  wire logic                wr_en,
    input  wire logic [2:0]          wr_index,
    input  wire logic [31:0]         wr_data,
    output logic                     valid,
    output logic [1:0]               corner,
    output logic [11:0]              vertex_number,
    output logic signed [15:0]       pos_x,
    output logic signed [15:0]       pos_y,
    output logic signed [15:0]       pos_z,
    output logic signed [1:0]        normal_z,
    output logic                     last
);

    localparam int QB  = tssv_pkg::QBITS;
    localparam int CS  = CORDIC_STEPS;
    localparam int M1  = 9 + QB + CS;
    localparam int M2  = M1 + 1;
    localparam int NST = M2 + 1;

    localparam logic signed [18:0] HALF_S    = 19'(tssv_pkg::HALF_TURN);
    localparam logic signed [18:0] FULL_S    = 19'(tssv_pkg::FULL_TURN);
    localparam logic signed [18:0] QUARTER_S = 19'(tssv_pkg::QUARTER_TURN);

    // Quotient magnitude with sign and overflow to a saturated coordinate
    function automatic tssv_pkg::coord_t q_to_coord(input logic [QB-1:0] q,
                                                    input logic sgn,
                                                    input logic ovf);
        tssv_pkg::coord_t r;
        if (!sgn)
            r = (ovf || q > QB'(32767)) ? 16'sh7FFF : 16'(q);
        else
            r = (ovf || q > QB'(32768)) ? 16'sh8000 : 16'(-q);
        return r;
    endfunction

    // Sign the product, round half away from zero from Q2.30, saturate
    function automatic tssv_pkg::coord_t round_sat(input logic signed [47:0] p,
                                                   input logic neg);
        logic signed [48:0] v;
        logic [48:0]        mag;
        logic [18:0]        r;
        tssv_pkg::coord_t   o;
        v   = {p[47], p};
        if (neg)
            v = -v;
        mag = v[48] ? 49'(-v) : 49'(v);
        r   = 19'((mag + 49'(1 << 29)) >> 30);
        if (!v[48])
            o = (r > 19'd32767) ? 16'sh7FFF : 16'(r);
        else
            o = (r > 19'd32768) ? 16'sh8000 : 16'(-r);
        return o;
    endfunction

    function automatic tssv_pkg::coord_t neg_sat(input tssv_pkg::coord_t a);
        return (a == 16'sh8000) ? 16'sh7FFF : 16'(-a);
    endfunction

    // ---------------- configuration registers ----------------
    logic [31:0]        pts_reg [4];
    logic signed [23:0] twist_reg;
    logic [10:0]        lcount_reg;

    // Capture register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                pts_reg[k] <= '0;
            twist_reg  <= '0;
            lcount_reg <= 11'd1;
        end
        else if (wr_en)
        begin
            case (tssv_pkg::reg_index_t'(wr_index))
                tssv_pkg::REG_POINT_ONE:   pts_reg[0] <= wr_data;
                tssv_pkg::REG_POINT_TWO:   pts_reg[1] <= wr_data;
                tssv_pkg::REG_POINT_THREE: pts_reg[2] <= wr_data;
                tssv_pkg::REG_POINT_FOUR:  pts_reg[3] <= wr_data;
                tssv_pkg::REG_TWIST:       twist_reg  <= $signed(wr_data[23:0]);
                tssv_pkg::REG_LEVEL_COUNT: lcount_reg <= wr_data[10:0];
                default: ;
            endcase
        end
    end

    // Effective level count and clamped level
    logic [10:0] n_lim;
    logic [10:0] n_m1;
    logic [9:0]  lv_clamp;
    always_comb
    begin
        if (lcount_reg == 11'd0)
            n_lim = 11'd1;
        else if (32'(lcount_reg) > MAX_LEVELS)
            n_lim = 11'(MAX_LEVELS);
        else
            n_lim = lcount_reg;
        n_m1     = n_lim - 11'd1;
        lv_clamp = ({1'b0, level} > n_m1) ? n_m1[9:0] : level;
    end

    // ---------------- input transfer and pacing ----------------
    logic       acc;
    logic [1:0] gap_reg;
    assign acc  = start && !busy;
    assign busy = (gap_reg != 2'd0);

    // Hold off the next level after a transfer until the gap counter runs out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else if (acc)
            gap_reg <= 2'd3;
        else if (gap_reg != 2'd0)
            gap_reg <= gap_reg - 2'd1;
    end

    // Stage valids and level tags travel together
    logic [NST-1:0] vld_reg;
    logic [9:0]     tag_reg [NST];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NST-2:0], acc};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= lv_clamp;
        for (int s = 1; s < NST; s++)
            tag_reg[s] <= tag_reg[s-1];
    end

    // ---------------- E0: lane indexes, biased twist ----------------
    logic [9:0]  e0_i_reg [2];
    logic [24:0] e0_tu_reg;
    always_ff @(posedge clk)
    begin
        e0_i_reg[0] <= lv_clamp;
        e0_i_reg[1] <= (lv_clamp == 10'd0) ? 10'd0 : lv_clamp - 10'd1;
        e0_tu_reg   <= {twist_reg[23], twist_reg} + tssv_pkg::TWIST_BIAS;
    end

    // ---------------- E1: squares, twist quotient ----------------
    logic [19:0] e1_i2_reg [2];
    logic [20:0] e1_in_reg [2];
    logic [9:0]  e1_i_reg  [2];
    logic [21:0] e1_n2_reg;
    logic [24:0] e1_tu_reg;
    logic [8:0]  e1_qt_reg;
    logic [52:0] e1_prod;
    assign e1_prod = 53'(e0_tu_reg) * 53'(tssv_pkg::TURN_RECIP);

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            e1_i2_reg[l] <= 20'(e0_i_reg[l]) * 20'(e0_i_reg[l]);
            e1_in_reg[l] <= 21'(e0_i_reg[l]) * 21'(n_lim);
            e1_i_reg[l]  <= e0_i_reg[l];
        end
        e1_n2_reg <= 22'(n_lim) * 22'(n_lim);
        e1_tu_reg <= e0_tu_reg;
        e1_qt_reg <= 9'(e1_prod >> tssv_pkg::TURN_SHIFT);
    end

    // ---------------- E2: cubes, twist remainder ----------------
    logic [29:0] e2_i3_reg  [2];
    logic [30:0] e2_i2n_reg [2];
    logic [31:0] e2_in2_reg [2];
    logic [9:0]  e2_i_reg   [2];
    logic [32:0] e2_n3_reg;
    logic [16:0] e2_tm_reg;
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            e2_i3_reg[l]  <= 30'(e1_i2_reg[l]) * 30'(e1_i_reg[l]);
            e2_i2n_reg[l] <= 31'(e1_i2_reg[l]) * 31'(n_lim);
            e2_in2_reg[l] <= 32'(e1_in_reg[l]) * 32'(n_lim);
            e2_i_reg[l]   <= e1_i_reg[l];
        end
        e2_n3_reg <= 33'(e1_n2_reg) * 33'(n_lim);
        e2_tm_reg <= 17'(e1_tu_reg - 25'(e1_qt_reg) * 25'(tssv_pkg::FULL_TURN));
    end

    // ---------------- E3: Catmull-Rom weights, lane angle ----------------
    logic signed [37:0] w_next [2][4];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            w_next[l][0] = -$signed({8'b0, e2_i3_reg[l]})
                         + ($signed({7'b0, e2_i2n_reg[l]}) <<< 1)
                         - $signed({6'b0, e2_in2_reg[l]});
            w_next[l][1] = 38'sd3 * $signed({8'b0, e2_i3_reg[l]})
                         - 38'sd5 * $signed({7'b0, e2_i2n_reg[l]})
                         + ($signed({5'b0, e2_n3_reg}) <<< 1);
            w_next[l][2] = -38'sd3 * $signed({8'b0, e2_i3_reg[l]})
                         + ($signed({7'b0, e2_i2n_reg[l]}) <<< 2)
                         + $signed({6'b0, e2_in2_reg[l]});
            w_next[l][3] = $signed({8'b0, e2_i3_reg[l]})
                         - $signed({7'b0, e2_i2n_reg[l]});
        end
    end

    logic signed [37:0] e3_c_reg [2][4];
    logic [32:0]        e3_n3_reg;
    logic [26:0]        e3_p_reg [2];
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < 4; k++)
                e3_c_reg[l][k] <= w_next[l][k];
            e3_p_reg[l] <= 27'(e2_tm_reg) * 27'(e2_i_reg[l]);
        end
        e3_n3_reg <= e2_n3_reg;
    end

    // ---------------- E4: weighted points, angle quotient ----------------
    logic signed [53:0] e4_pr_reg [2][2][4];
    logic [10:0]        e4_qp_reg [2];
    logic [26:0]        e4_p_reg  [2];
    logic [32:0]        e4_n3_reg;
    logic [54:0]        e4_prod   [2];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
            e4_prod[l] = 55'(e3_p_reg[l]) * 55'(tssv_pkg::TURN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int d = 0; d < 2; d++)
                for (int k = 0; k < 4; k++)
                    e4_pr_reg[l][d][k] <= e3_c_reg[l][k] * $signed(pts_reg[k][16*d +: 16]);
            e4_qp_reg[l] <= 11'(e4_prod[l] >> tssv_pkg::TURN_SHIFT);
            e4_p_reg[l]  <= e3_p_reg[l];
        end
        e4_n3_reg <= e3_n3_reg;
    end

    // ---------------- E5: pair sums, angle remainder ----------------
    logic signed [54:0] e5_s_reg [2][2][2];
    logic [16:0]        e5_r_reg [2];
    logic [32:0]        e5_n3_reg;
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                e5_s_reg[l][d][0] <= 55'(e4_pr_reg[l][d][0]) + 55'(e4_pr_reg[l][d][1]);
                e5_s_reg[l][d][1] <= 55'(e4_pr_reg[l][d][2]) + 55'(e4_pr_reg[l][d][3]);
            end
            e5_r_reg[l] <= 17'(e4_p_reg[l] - 27'(e4_qp_reg[l]) * 27'(tssv_pkg::FULL_TURN));
        end
        e5_n3_reg <= e4_n3_reg;
    end

    // ---------------- E6: full sums, fold angle into +-90 degrees ----------------
    logic signed [18:0] rr_next  [2];
    logic               neg_next [2];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            rr_next[l]  = $signed({2'b0, e5_r_reg[l]});
            neg_next[l] = 1'b0;
            if (rr_next[l] >= HALF_S)
                rr_next[l] = rr_next[l] - FULL_S;
            if (rr_next[l] > QUARTER_S)
            begin
                rr_next[l]  = rr_next[l] - HALF_S;
                neg_next[l] = 1'b1;
            end
            else if (rr_next[l] < -QUARTER_S)
            begin
                rr_next[l]  = rr_next[l] + HALF_S;
                neg_next[l] = 1'b1;
            end
        end
    end

    logic signed [55:0] e6_num_reg [2][2];
    logic signed [25:0] e6_z_reg   [2];
    logic               e6_neg_reg [2];
    logic [32:0]        e6_n3_reg;
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int d = 0; d < 2; d++)
                e6_num_reg[l][d] <= 56'(e5_s_reg[l][d][0]) + 56'(e5_s_reg[l][d][1]);
            e6_z_reg[l]   <= {rr_next[l][17:0], 8'b0};
            e6_neg_reg[l] <= neg_next[l];
        end
        e6_n3_reg <= e5_n3_reg;
    end

    // ---------------- E7 and divider: restoring, one quotient bit a stage ----------------
    logic [56:0]        dv_rem_reg [QB+1][2][2];
    logic [QB-1:0]      dv_q_reg   [QB+1][2][2];
    logic               dv_sgn_reg [QB+1][2][2];
    logic               dv_ovf_reg [QB+1][2][2];
    logic [33:0]        dv_den_reg [QB+1];
    logic signed [25:0] dv_z_reg   [QB+1][2];
    logic               dv_neg_reg [QB+1][2];

    logic [55:0] mag_next [2][2];
    logic [56:0] a_next   [2][2];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
            for (int d = 0; d < 2; d++)
            begin
                mag_next[l][d] = e6_num_reg[l][d][55] ? 56'(-e6_num_reg[l][d])
                                                      : 56'(e6_num_reg[l][d]);
                a_next[l][d]   = 57'(mag_next[l][d]) + 57'(e6_n3_reg);
            end
    end

    // Add half the divisor to the magnitude, flag quotients past the kept bits
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                dv_rem_reg[0][l][d] <= a_next[l][d];
                dv_q_reg[0][l][d]   <= '0;
                dv_sgn_reg[0][l][d] <= e6_num_reg[l][d][55];
                dv_ovf_reg[0][l][d] <= (a_next[l][d] >> QB) >= 57'({e6_n3_reg, 1'b0});
            end
            dv_z_reg[0][l]   <= e6_z_reg[l];
            dv_neg_reg[0][l] <= e6_neg_reg[l];
        end
        dv_den_reg[0] <= {e6_n3_reg, 1'b0};
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int B = QB - 1 - j;
        logic [56:0] trial;
        assign trial = 57'(dv_den_reg[j]) << B;

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            for (genvar d = 0; d < 2; d++)
            begin : g_coord
                logic take;
                assign take = dv_rem_reg[j][l][d] >= trial;

                // Subtract the shifted divisor where it fits, set the quotient bit
                always_ff @(posedge clk)
                begin
                    dv_rem_reg[j+1][l][d] <= take ? dv_rem_reg[j][l][d] - trial
                                                  : dv_rem_reg[j][l][d];
                    dv_q_reg[j+1][l][d]   <= dv_q_reg[j][l][d]
                                           | (take ? (QB'(1) << B) : QB'(0));
                    dv_sgn_reg[j+1][l][d] <= dv_sgn_reg[j][l][d];
                    dv_ovf_reg[j+1][l][d] <= dv_ovf_reg[j][l][d];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_z_reg[j+1][l]   <= dv_z_reg[j][l];
                dv_neg_reg[j+1][l] <= dv_neg_reg[j][l];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_den_reg[j+1] <= dv_den_reg[j];
        end
    end

    // ---------------- saturate curve point, seed CORDIC ----------------
    logic signed [31:0]  cr_x_reg   [CS+1][2];
    logic signed [31:0]  cr_y_reg   [CS+1][2];
    logic signed [25:0]  cr_z_reg   [CS+1][2];
    logic                cr_neg_reg [CS+1][2];
    tssv_pkg::coord_t    cr_px_reg  [CS+1][2];
    tssv_pkg::coord_t    cr_py_reg  [CS+1][2];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            cr_x_reg[0][l]   <= tssv_pkg::CORDIC_GAIN;
            cr_y_reg[0][l]   <= '0;
            cr_z_reg[0][l]   <= dv_z_reg[QB][l];
            cr_neg_reg[0][l] <= dv_neg_reg[QB][l];
            cr_px_reg[0][l]  <= q_to_coord(dv_q_reg[QB][l][0], dv_sgn_reg[QB][l][0],
                                           dv_ovf_reg[QB][l][0]);
            cr_py_reg[0][l]  <= q_to_coord(dv_q_reg[QB][l][1], dv_sgn_reg[QB][l][1],
                                           dv_ovf_reg[QB][l][1]);
        end
    end

    // ---------------- CORDIC rotation, one micro-rotation a stage ----------------
    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        localparam logic signed [25:0] ATAN = $signed({4'b0, tssv_pkg::atan_entry(5'(k))});

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic signed [31:0] dx;
            logic signed [31:0] dy;
            assign dx = cr_y_reg[k][l] >>> k;
            assign dy = cr_x_reg[k][l] >>> k;

            // Rotate toward zero residual angle
            always_ff @(posedge clk)
            begin
                if (!cr_z_reg[k][l][25])
                begin
                    cr_x_reg[k+1][l] <= cr_x_reg[k][l] - dx;
                    cr_y_reg[k+1][l] <= cr_y_reg[k][l] + dy;
                    cr_z_reg[k+1][l] <= cr_z_reg[k][l] - ATAN;
                end
                else
                begin
                    cr_x_reg[k+1][l] <= cr_x_reg[k][l] + dx;
                    cr_y_reg[k+1][l] <= cr_y_reg[k][l] - dy;
                    cr_z_reg[k+1][l] <= cr_z_reg[k][l] + ATAN;
                end
                cr_neg_reg[k+1][l] <= cr_neg_reg[k][l];
                cr_px_reg[k+1][l]  <= cr_px_reg[k][l];
                cr_py_reg[k+1][l]  <= cr_py_reg[k][l];
            end
        end
    end

    // ---------------- M1: y times cos and sin ----------------
    logic signed [47:0] m1_c_reg   [2];
    logic signed [47:0] m1_s_reg   [2];
    logic               m1_neg_reg [2];
    tssv_pkg::coord_t   m1_x_reg   [2];
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            m1_c_reg[l]   <= cr_py_reg[CS][l] * cr_x_reg[CS][l];
            m1_s_reg[l]   <= cr_py_reg[CS][l] * cr_y_reg[CS][l];
            m1_neg_reg[l] <= cr_neg_reg[CS][l];
            m1_x_reg[l]   <= cr_px_reg[CS][l];
        end
    end

    // ---------------- M2: round and saturate rotated coordinates ----------------
    tssv_pkg::coord_t m2_x_reg [2];
    tssv_pkg::coord_t m2_y_reg [2];
    tssv_pkg::coord_t m2_z_reg [2];
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            m2_x_reg[l] <= m1_x_reg[l];
            m2_y_reg[l] <= round_sat(m1_c_reg[l], m1_neg_reg[l]);
            m2_z_reg[l] <= round_sat(m1_s_reg[l], m1_neg_reg[l]);
        end
    end

    // ---------------- quad assembly and normal ----------------
    tssv_pkg::coord_t  prev_x;
    tssv_pkg::coord_t  prev_y;
    tssv_pkg::coord_t  prev_z;
    logic signed [16:0] dx_cp;
    logic signed [1:0]  nz_next;
    always_comb
    begin
        if (tag_reg[M2] == 10'd0)
        begin
            prev_x = $signed(pts_reg[1][15:0]);
            prev_y = $signed(pts_reg[1][31:16]);
            prev_z = '0;
        end
        else
        begin
            prev_x = m2_x_reg[1];
            prev_y = m2_y_reg[1];
            prev_z = m2_z_reg[1];
        end
        // Cross product sign reduces to sign(prev y) * sign(cur x - prev x)
        dx_cp = 17'(m2_x_reg[0]) - 17'(prev_x);
        if (prev_y == 16'sd0 || dx_cp == 17'sd0)
            nz_next = 2'sd0;
        else if (prev_y[15] == dx_cp[16])
            nz_next = 2'sd1;
        else
            nz_next = -2'sd1;
    end

    // ---------------- output buffer and serializer ----------------
    tssv_pkg::coord_t   ob_prev_reg [3];
    tssv_pkg::coord_t   ob_cur_reg  [3];
    logic signed [1:0]  ob_nz_reg;
    logic [9:0]         ob_lv_reg;

    always_ff @(posedge clk)
    begin
        if (vld_reg[M2])
        begin
            ob_prev_reg[0] <= prev_x;
            ob_prev_reg[1] <= prev_y;
            ob_prev_reg[2] <= prev_z;
            ob_cur_reg[0]  <= m2_x_reg[0];
            ob_cur_reg[1]  <= m2_y_reg[0];
            ob_cur_reg[2]  <= m2_z_reg[0];
            ob_nz_reg      <= nz_next;
            ob_lv_reg      <= tag_reg[M2];
        end
    end

    logic act_reg;
    logic [1:0] cnt_reg;

    // Start a quad on a finished level, advance one corner per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (vld_reg[M2])
        begin
            act_reg <= 1'b1;
            cnt_reg <= tssv_pkg::CORNER_LL;
        end
        else if (act_reg)
        begin
            if (cnt_reg == tssv_pkg::CORNER_UR)
                act_reg <= 1'b0;
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    // Select the corner being transferred
    always_comb
    begin
        case (tssv_pkg::corner_t'(cnt_reg))
            tssv_pkg::CORNER_LL:
            begin
                pos_x = ob_prev_reg[0];
                pos_y = ob_prev_reg[1];
                pos_z = ob_prev_reg[2];
            end
            tssv_pkg::CORNER_UL:
            begin
                pos_x = ob_cur_reg[0];
                pos_y = ob_cur_reg[1];
                pos_z = ob_cur_reg[2];
            end
            tssv_pkg::CORNER_LR:
            begin
                pos_x = ob_prev_reg[0];
                pos_y = neg_sat(ob_prev_reg[1]);
                pos_z = neg_sat(ob_prev_reg[2]);
            end
            default:
            begin
                pos_x = ob_cur_reg[0];
                pos_y = neg_sat(ob_cur_reg[1]);
                pos_z = neg_sat(ob_cur_reg[2]);
            end
        endcase
    end

    assign valid         = act_reg;
    assign corner        = cnt_reg;
    assign vertex_number = {ob_lv_reg, cnt_reg};
    assign normal_z      = ob_nz_reg;
    assign last          = (cnt_reg == tssv_pkg::CORNER_UR);

endmodule

`default_nettype wire
